// ===== rtl/sbt_pkg.sv =====
// Shared types, codes and sizes of the software breakpoint table.
`timescale 1ns / 1ps
`default_nettype none

package sbt_pkg;

   // Table geometry
   localparam int MaxEntries = 32;
   localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CountW     = $clog2(MaxEntries + 1);

   // Request and response field widths
   localparam int KindW     = 3;
   localparam int AddrW     = 32;
   localparam int HalfW     = 16;
   localparam int StatusW   = 2;
   localparam int EntryIdxW = 5;

   // Breakpoint opcode patched into instruction memory
   localparam logic [HalfW-1:0] BreakOpcode = 16'hBE00;

   // Request kinds
   localparam logic [KindW-1:0] KIND_INSERT  = 3'd0;
   localparam logic [KindW-1:0] KIND_REMOVE  = 3'd1;
   localparam logic [KindW-1:0] KIND_SUSPEND = 3'd2;
   localparam logic [KindW-1:0] KIND_RESUME  = 3'd3;
   localparam logic [KindW-1:0] KIND_CLEAR   = 3'd4;

   // Response status codes
   typedef enum logic [StatusW-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_PRESENT = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_ABSENT  = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_CLR_RD,
      ST_CLR_EMIT,
      ST_OTHER
   } state_type;

   // One stored table entry
   typedef struct packed {
      logic [AddrW-1:0] address;
      logic [HalfW-1:0] original;
   } entry_type;

   // Access command from the sequencer to the entry memory
   typedef struct packed {
      logic            wr_en;
      logic [IdxW-1:0] wr_idx;
      entry_type       wr_data;
      logic            rd_en;
      logic [IdxW-1:0] rd_idx;
   } mem_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/sbt_req_if.sv =====
// Request channel of the software breakpoint table.
`timescale 1ns / 1ps
`default_nettype none

interface sbt_req_if;
   logic                      valid;
   logic                      ready;
   logic [sbt_pkg::KindW-1:0] kind;
   logic [sbt_pkg::AddrW-1:0] address;
   logic [sbt_pkg::HalfW-1:0] flash_halfword;

   modport source (output valid, output kind, output address, output flash_halfword,
                   input ready);
   modport sink   (input valid, input kind, input address, input flash_halfword,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sbt_rsp_if.sv =====
// Response channel of the software breakpoint table.
`timescale 1ns / 1ps
`default_nettype none

interface sbt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sbt_pkg::StatusW-1:0]   status;
   logic [sbt_pkg::EntryIdxW-1:0] entry_index;
   logic                          write_enable;
   logic [sbt_pkg::AddrW-1:0]     write_address;
   logic [sbt_pkg::HalfW-1:0]     write_halfword;
   logic                          last;

   modport source (output valid, output status, output entry_index, output write_enable,
                   output write_address, output write_halfword, output last,
                   input ready);
   modport sink   (input valid, input status, input entry_index, input write_enable,
                   input write_address, input write_halfword, input last,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/software_breakpoint_table_top.sv =====
// Top level of the software breakpoint table: sequencer plus entry memory.
`timescale 1ns / 1ps
`default_nettype none

// Software breakpoint table for up to 32 addresses. Each request (insert, remove,
// suspend, resume, clear) yields one or more responses telling which instruction
// halfword to write; clear yields one response per patched entry, flagged last on
// the final one. Lookups walk the stored entries through the single read port of the
// entry memory, one entry per cycle with one shared address comparator; the response
// is loaded, once the output register is free, on a hit or after all stored entries
// have missed. Remove then reads the last entry and writes it into the freed slot,
// and clear walks the active marks, reading and restoring each patched entry in turn.
// One request is in work at a time; a finished response waits in an output register
// while the next request is taken. No clearing pass is needed after reset: of the
// table itself only the active marks and the entry count are reset.
module software_breakpoint_table_top (
   input  wire logic clock,
   input  wire logic reset,
   sbt_req_if.sink   req_ch,
   sbt_rsp_if.source rsp_ch
);

   sbt_pkg::mem_cmd_type mem_cmd;
   sbt_pkg::entry_type   mem_rd_data;

   sbt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_cmd     (mem_cmd),
      .mem_rd_data (mem_rd_data)
   );

   sbt_mem u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (mem_rd_data)
   );

   // Busy after taking a request
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while previous one still in work");

   // Memory is touched only while a request is in work, one access per cycle
   a_mem_access : assert property (@(posedge clock) disable iff (reset)
      (mem_cmd.wr_en || mem_cmd.rd_en) |-> !req_ch.ready && !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("entry memory accessed while idle or twice in a cycle");

   // A halfword write is only reported with a done status
   a_write_done : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.write_enable |-> rsp_ch.status == sbt_pkg::STATUS_DONE)
      else $error("write reported with a failure status");

endmodule

`default_nettype wire

// ===== rtl/sbt_mem.sv =====
// Entry memory: breakpoint address and saved halfword, one write and one registered read.
`timescale 1ns / 1ps
`default_nettype none

module sbt_mem (
   input  wire logic                 clock,
   input  wire sbt_pkg::mem_cmd_type cmd,
   output sbt_pkg::entry_type        rd_data
);

   sbt_pkg::entry_type mem [sbt_pkg::MaxEntries];
   sbt_pkg::entry_type rd_data_ff;

   // Write and read the entry array
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sbt_ctrl.sv =====
// Command sequencer: entry scan and compare, active marks, count and response register.
`timescale 1ns / 1ps
`default_nettype none

module sbt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   sbt_req_if.sink                    req_ch,
   sbt_rsp_if.source                  rsp_ch,
   output sbt_pkg::mem_cmd_type       mem_cmd,
   input  wire sbt_pkg::entry_type    mem_rd_data
);

   localparam int IdxW   = sbt_pkg::IdxW;
   localparam int CountW = sbt_pkg::CountW;
   localparam int MaxE   = sbt_pkg::MaxEntries;

   sbt_pkg::state_type state_ff, state_in;

   logic [sbt_pkg::KindW-1:0] kind_ff, kind_in;
   logic [sbt_pkg::AddrW-1:0] addr_ff, addr_in;
   logic [sbt_pkg::HalfW-1:0] half_ff, half_in;

   logic [CountW-1:0] scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [IdxW-1:0]   pidx_ff, pidx_in;
   logic [IdxW-1:0]   slot_ff, slot_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [MaxE-1:0]   active_ff, active_in;

   logic                          rsp_vld_ff, rsp_vld_in;
   logic [sbt_pkg::StatusW-1:0]   rsp_status_ff, rsp_status_in;
   logic [sbt_pkg::EntryIdxW-1:0] rsp_idx_ff, rsp_idx_in;
   logic                          rsp_we_ff, rsp_we_in;
   logic [sbt_pkg::AddrW-1:0]     rsp_waddr_ff, rsp_waddr_in;
   logic [sbt_pkg::HalfW-1:0]     rsp_whalf_ff, rsp_whalf_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Result being loaded this cycle
   logic                          ld;
   sbt_pkg::status_type           ld_status;
   logic [sbt_pkg::EntryIdxW-1:0] ld_idx;
   logic                          ld_we;
   logic [sbt_pkg::AddrW-1:0]     ld_waddr;
   logic [sbt_pkg::HalfW-1:0]     ld_whalf;
   logic                          ld_last;

   logic            accept;
   logic            slot_free;
   logic            hit;
   logic            miss;
   logic            resolve;
   logic            full;
   logic [IdxW-1:0] cur_idx;
   logic [IdxW-1:0] last_idx;
   logic [MaxE-1:0] ge_vec;
   logic [MaxE-1:0] gt_vec;
   logic            ge_any;
   logic            gt_any;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_vld_ff || rsp_ch.ready;

   // Shared compare: the entry read last cycle against the request address
   assign hit     = pend_ff && (mem_rd_data.address == addr_ff);
   assign miss    = !hit && (scan_ff >= count_ff);
   assign resolve = hit || miss;
   assign full    = (count_ff >= CountW'(MaxE));

   assign cur_idx  = scan_ff[IdxW-1:0];
   assign last_idx = IdxW'(count_ff - CountW'(1));

   // Active marks at or beyond the clear walk position
   always_comb begin
      for (int j = 0; j < MaxE; j++) begin
         ge_vec[j] = active_ff[j] && (CountW'(j) >= scan_ff);
         gt_vec[j] = active_ff[j] && (CountW'(j) > scan_ff);
      end
   end

   assign ge_any = |ge_vec;
   assign gt_any = |gt_vec;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ch.kind == sbt_pkg::KIND_INSERT  || req_ch.kind == sbt_pkg::KIND_REMOVE ||
                   req_ch.kind == sbt_pkg::KIND_SUSPEND || req_ch.kind == sbt_pkg::KIND_RESUME) begin
                  state_in = sbt_pkg::ST_SCAN;
               end else if (req_ch.kind == sbt_pkg::KIND_CLEAR) begin
                  state_in = sbt_pkg::ST_CLR_RD;
               end else begin
                  state_in = sbt_pkg::ST_OTHER;
               end
            end
         end
         sbt_pkg::ST_SCAN: begin
            if (resolve && slot_free) begin
               state_in = (kind_ff == sbt_pkg::KIND_REMOVE && hit) ?
                          sbt_pkg::ST_MOVE_RD : sbt_pkg::ST_IDLE;
            end
         end
         sbt_pkg::ST_MOVE_RD: state_in = sbt_pkg::ST_MOVE_WR;
         sbt_pkg::ST_MOVE_WR: state_in = sbt_pkg::ST_IDLE;
         sbt_pkg::ST_CLR_RD: begin
            if (!ge_any) begin
               if (slot_free) begin
                  state_in = sbt_pkg::ST_IDLE;
               end
            end else if (active_ff[cur_idx]) begin
               state_in = sbt_pkg::ST_CLR_EMIT;
            end
         end
         sbt_pkg::ST_CLR_EMIT: begin
            if (slot_free) begin
               state_in = gt_any ? sbt_pkg::ST_CLR_RD : sbt_pkg::ST_IDLE;
            end
         end
         sbt_pkg::ST_OTHER: begin
            if (slot_free) begin
               state_in = sbt_pkg::ST_IDLE;
            end
         end
         default: state_in = sbt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control per state
   always_comb begin
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      half_in   = half_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      pidx_in   = pidx_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      active_in = active_ff;
      mem_cmd   = '0;
      ld        = 1'b0;
      ld_status = sbt_pkg::STATUS_DONE;
      ld_idx    = '0;
      ld_we     = 1'b0;
      ld_waddr  = '0;
      ld_whalf  = '0;
      ld_last   = 1'b1;

      unique case (state_ff)
         sbt_pkg::ST_IDLE: begin
            // Capture the request and restart the scan
            if (accept) begin
               kind_in = req_ch.kind;
               addr_in = req_ch.address;
               half_in = req_ch.flash_halfword;
               scan_in = '0;
               pend_in = 1'b0;
            end
         end
         sbt_pkg::ST_SCAN: begin
            if (!resolve) begin
               // Read the next entry for comparison
               mem_cmd.rd_en = 1'b1;
               mem_cmd.rd_idx = cur_idx;
               pend_in = 1'b1;
               pidx_in = cur_idx;
               scan_in = scan_ff + CountW'(1);
            end else if (slot_free) begin
               ld      = 1'b1;
               pend_in = 1'b0;
               unique case (kind_ff)
                  sbt_pkg::KIND_INSERT: begin
                     if (hit) begin
                        ld_status = sbt_pkg::STATUS_PRESENT;
                        ld_idx    = sbt_pkg::EntryIdxW'(pidx_ff);
                     end else if (full) begin
                        ld_status = sbt_pkg::STATUS_FULL;
                     end else begin
                        // Append the entry and patch in the breakpoint
                        ld_idx                   = sbt_pkg::EntryIdxW'(count_ff);
                        ld_we                    = 1'b1;
                        ld_waddr                 = addr_ff;
                        ld_whalf                 = sbt_pkg::BreakOpcode;
                        mem_cmd.wr_en            = 1'b1;
                        mem_cmd.wr_idx           = IdxW'(count_ff);
                        mem_cmd.wr_data.address  = addr_ff;
                        mem_cmd.wr_data.original = half_ff;
                        active_in[IdxW'(count_ff)] = 1'b1;
                        count_in                 = count_ff + CountW'(1);
                     end
                  end
                  sbt_pkg::KIND_REMOVE: begin
                     if (hit) begin
                        // Restore if patched, then pull the last entry into the hole
                        ld_idx   = sbt_pkg::EntryIdxW'(pidx_ff);
                        ld_we    = active_ff[pidx_ff];
                        ld_waddr = active_ff[pidx_ff] ? addr_ff : '0;
                        ld_whalf = active_ff[pidx_ff] ? mem_rd_data.original : '0;
                        count_in = count_ff - CountW'(1);
                        slot_in  = pidx_ff;
                        active_in[pidx_ff]  = active_ff[last_idx];
                        active_in[last_idx] = 1'b0;
                     end else begin
                        ld_status = sbt_pkg::STATUS_ABSENT;
                     end
                  end
                  sbt_pkg::KIND_SUSPEND: begin
                     if (hit) begin
                        ld_idx = sbt_pkg::EntryIdxW'(pidx_ff);
                        if (active_ff[pidx_ff]) begin
                           ld_we    = 1'b1;
                           ld_waddr = addr_ff;
                           ld_whalf = mem_rd_data.original;
                           active_in[pidx_ff] = 1'b0;
                        end
                     end else begin
                        ld_status = sbt_pkg::STATUS_ABSENT;
                     end
                  end
                  sbt_pkg::KIND_RESUME: begin
                     if (hit) begin
                        ld_idx = sbt_pkg::EntryIdxW'(pidx_ff);
                        if (!active_ff[pidx_ff]) begin
                           ld_we    = 1'b1;
                           ld_waddr = addr_ff;
                           ld_whalf = sbt_pkg::BreakOpcode;
                           active_in[pidx_ff] = 1'b1;
                        end
                     end else begin
                        ld_status = sbt_pkg::STATUS_ABSENT;
                     end
                  end
                  default: begin
                     ld_status = sbt_pkg::STATUS_DONE;
                  end
               endcase
            end
         end
         sbt_pkg::ST_MOVE_RD: begin
            // Fetch the last entry (count already decremented)
            mem_cmd.rd_en  = 1'b1;
            mem_cmd.rd_idx = IdxW'(count_ff);
         end
         sbt_pkg::ST_MOVE_WR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_idx  = slot_ff;
            mem_cmd.wr_data = mem_rd_data;
         end
         sbt_pkg::ST_CLR_RD: begin
            if (!ge_any) begin
               // Nothing patched: single empty result, then drop the table
               if (slot_free) begin
                  ld        = 1'b1;
                  active_in = '0;
                  count_in  = '0;
               end
            end else if (active_ff[cur_idx]) begin
               mem_cmd.rd_en  = 1'b1;
               mem_cmd.rd_idx = cur_idx;
            end else begin
               scan_in = scan_ff + CountW'(1);
            end
         end
         sbt_pkg::ST_CLR_EMIT: begin
            // Restore one patched entry
            if (slot_free) begin
               ld       = 1'b1;
               ld_idx   = sbt_pkg::EntryIdxW'(cur_idx);
               ld_we    = 1'b1;
               ld_waddr = mem_rd_data.address;
               ld_whalf = mem_rd_data.original;
               ld_last  = !gt_any;
               scan_in  = scan_ff + CountW'(1);
               if (!gt_any) begin
                  active_in = '0;
                  count_in  = '0;
               end
            end
         end
         sbt_pkg::ST_OTHER: begin
            if (slot_free) begin
               ld = 1'b1;
            end
         end
         default: begin
            ld = 1'b0;
         end
      endcase
   end

   // Response register: load a new request result or drop the taken one
   always_comb begin
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_we_in     = rsp_we_ff;
      rsp_waddr_in  = rsp_waddr_ff;
      rsp_whalf_in  = rsp_whalf_ff;
      rsp_last_in   = rsp_last_ff;
      if (ld) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = ld_status;
         rsp_idx_in    = ld_idx;
         rsp_we_in     = ld_we;
         rsp_waddr_in  = ld_waddr;
         rsp_whalf_in  = ld_whalf;
         rsp_last_in   = ld_last;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sbt_pkg::ST_IDLE;
         pend_ff    <= 1'b0;
         count_ff   <= '0;
         active_ff  <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         count_ff   <= count_in;
         active_ff  <= active_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      addr_ff       <= addr_in;
      half_ff       <= half_in;
      scan_ff       <= scan_in;
      pidx_ff       <= pidx_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_we_ff     <= rsp_we_in;
      rsp_waddr_ff  <= rsp_waddr_in;
      rsp_whalf_ff  <= rsp_whalf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ch.ready          = (state_ff == sbt_pkg::ST_IDLE);
   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.entry_index    = rsp_idx_ff;
   assign rsp_ch.write_enable   = rsp_we_ff;
   assign rsp_ch.write_address  = rsp_waddr_ff;
   assign rsp_ch.write_halfword = rsp_whalf_ff;
   assign rsp_ch.last           = rsp_last_ff;

endmodule

`default_nettype wire

// ===== verif/software_breakpoint_table_checker.sv =====
// Checker for the software breakpoint table: tracks the patch table and compares every response.
`timescale 1ns / 1ps

module software_breakpoint_table_checker (
   input  wire logic clock,
   input  wire logic reset,
   sbt_req_if        req_ch,
   sbt_rsp_if        rsp_ch,
   output int        mismatch_count,
   output int        patches_pending
);
   import sbt_pkg::*;

   // One memory patch response as the block should report it
   typedef struct packed {
      status_type           status;
      logic [EntryIdxW-1:0] entry_index;
      logic                 write_enable;
      logic [AddrW-1:0]     write_address;
      logic [HalfW-1:0]     write_halfword;
      logic                 last;
   } patch_type;

   // Shadow copy of the breakpoint table
   logic [AddrW-1:0] bp_addr [MaxEntries];
   logic [HalfW-1:0] bp_orig [MaxEntries];
   bit               bp_armed[MaxEntries];
   int               bp_count;

   patch_type expected_patches[$];
   int        fault_total = 0;
   int        open_count  = 0;

   assign mismatch_count  = fault_total;
   assign patches_pending = open_count;

   // Return the slot holding an address, or -1 when it is not in the table
   function automatic int find_slot(input logic [AddrW-1:0] addr);
      for (int i = 0; i < bp_count; i++)
         if (bp_addr[i] == addr)
            return i;
      return -1;
   endfunction

   // Queue one expected response; address and halfword read zero without a write
   function automatic void queue_patch(input status_type st, input int slot, input logic we,
                                       input logic [AddrW-1:0] waddr,
                                       input logic [HalfW-1:0] whalf, input logic fin);
      patch_type p;
      p.status         = st;
      p.entry_index    = EntryIdxW'(slot);
      p.write_enable   = we;
      p.write_address  = we ? waddr : '0;
      p.write_halfword = we ? whalf : '0;
      p.last           = fin;
      expected_patches.push_back(p);
   endfunction

   // Apply one request to the shadow table and queue its responses
   function automatic void predict_request(input logic [KindW-1:0] kind,
                                           input logic [AddrW-1:0] addr,
                                           input logic [HalfW-1:0] half);
      int slot;
      int final_slot;
      slot = find_slot(addr);
      case (kind)
         KIND_INSERT: begin
            if (slot >= 0) begin
               queue_patch(STATUS_PRESENT, slot, 1'b0, '0, '0, 1'b1);
            end else if (bp_count >= MaxEntries) begin
               queue_patch(STATUS_FULL, 0, 1'b0, '0, '0, 1'b1);
            end else begin
               bp_addr[bp_count]  = addr;
               bp_orig[bp_count]  = half;
               bp_armed[bp_count] = 1'b1;
               queue_patch(STATUS_DONE, bp_count, 1'b1, addr, BreakOpcode, 1'b1);
               bp_count++;
            end
         end
         KIND_REMOVE: begin
            if (slot < 0) begin
               queue_patch(STATUS_ABSENT, 0, 1'b0, '0, '0, 1'b1);
            end else begin
               // restore if patched, then move the last entry into the hole
               queue_patch(STATUS_DONE, slot, bp_armed[slot], addr, bp_orig[slot], 1'b1);
               bp_count--;
               bp_addr[slot]      = bp_addr[bp_count];
               bp_orig[slot]      = bp_orig[bp_count];
               bp_armed[slot]     = bp_armed[bp_count];
               bp_armed[bp_count] = 1'b0;
            end
         end
         KIND_SUSPEND, KIND_RESUME: begin
            if (slot < 0) begin
               queue_patch(STATUS_ABSENT, 0, 1'b0, '0, '0, 1'b1);
            end else if (kind == KIND_SUSPEND && bp_armed[slot]) begin
               bp_armed[slot] = 1'b0;
               queue_patch(STATUS_DONE, slot, 1'b1, addr, bp_orig[slot], 1'b1);
            end else if (kind == KIND_RESUME && !bp_armed[slot]) begin
               bp_armed[slot] = 1'b1;
               queue_patch(STATUS_DONE, slot, 1'b1, addr, BreakOpcode, 1'b1);
            end else begin
               queue_patch(STATUS_DONE, slot, 1'b0, '0, '0, 1'b1);
            end
         end
         KIND_CLEAR: begin
            final_slot = -1;
            for (int i = 0; i < bp_count; i++)
               if (bp_armed[i])
                  final_slot = i;
            if (final_slot < 0) begin
               queue_patch(STATUS_DONE, 0, 1'b0, '0, '0, 1'b1);
            end else begin
               // one restore per patched entry, in slot order
               for (int i = 0; i <= final_slot; i++)
                  if (bp_armed[i])
                     queue_patch(STATUS_DONE, i, 1'b1, bp_addr[i], bp_orig[i],
                                 i == final_slot);
            end
            for (int i = 0; i < MaxEntries; i++)
               bp_armed[i] = 1'b0;
            bp_count = 0;
         end
         default: begin
            queue_patch(STATUS_DONE, 0, 1'b0, '0, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void check_field(input string field, input logic [AddrW-1:0] want,
                                       input logic [AddrW-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
         fault_total++;
      end
   endfunction

   // Compare responses first, then predict from the request taken at the same edge
   always @(posedge clock) begin : watch_channels
      patch_type want;
      if (reset) begin
         bp_count = 0;
         for (int i = 0; i < MaxEntries; i++)
            bp_armed[i] = 1'b0;
         expected_patches.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_patches.size() == 0) begin
               $error("response with no request pending: status %0d entry %0d",
                      rsp_ch.status, rsp_ch.entry_index);
               fault_total++;
            end else begin
               want = expected_patches.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("entry_index", want.entry_index, rsp_ch.entry_index);
               check_field("write_enable", want.write_enable, rsp_ch.write_enable);
               check_field("write_address", want.write_address, rsp_ch.write_address);
               check_field("write_halfword", want.write_halfword, rsp_ch.write_halfword);
               check_field("last", want.last, rsp_ch.last);
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_request(req_ch.kind, req_ch.address, req_ch.flash_halfword);
      end
      open_count = expected_patches.size();
   end

endmodule

// ===== verif/tb_software_breakpoint_table_top.sv =====
// Testbench top for the software breakpoint table: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module tb_software_breakpoint_table_top;
   import sbt_pkg::*;

   localparam int                 PoolSize        = 40;
   localparam int                 PhaseRequests   = 50;
   localparam int                 HoldCycles      = 300;
   localparam logic [KindW-1:0]   KindUnusedFirst = KIND_CLEAR + 1'b1;
   localparam logic [KindW-1:0]   KindUnusedLast  = '1;

   logic clock;
   logic reset;
   logic hold_rsp = 1'b0;
   bit   hold_go  = 1'b0;
   int   sender_gap_pct     = 0;
   int   receiver_stall_pct = 0;
   int   mismatch_count;
   int   patches_pending;

   logic [AddrW-1:0] bp_pool[PoolSize];

   sbt_req_if req_ch ();
   sbt_rsp_if rsp_ch ();

   software_breakpoint_table_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   software_breakpoint_table_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .mismatch_count  (mismatch_count),
      .patches_pending (patches_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: random stalls, plus the long hold-off when it is active
   always @(posedge clock) begin
      if (reset || hold_rsp)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Hold off the response side for a fixed stretch once pressure starts
   initial begin : long_hold
      wait (hold_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Offer one request, with an optional idle gap first, and wait until it is taken
   task automatic issue_request(input logic [KindW-1:0] kind, input logic [AddrW-1:0] addr,
                                input logic [HalfW-1:0] half);
      if ($urandom_range(99) < sender_gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_ch.valid          <= 1'b1;
      req_ch.kind           <= kind;
      req_ch.address        <= addr;
      req_ch.flash_halfword <= half;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Mostly table addresses so that hits are common, sometimes anything at all
   task automatic random_request();
      logic [KindW-1:0] kind;
      logic [AddrW-1:0] addr;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 38)      kind = KIND_INSERT;
      else if (pick < 56) kind = KIND_REMOVE;
      else if (pick < 74) kind = KIND_SUSPEND;
      else if (pick < 92) kind = KIND_RESUME;
      else if (pick < 96) kind = KIND_CLEAR;
      else                kind = KindW'($urandom_range(KindUnusedFirst, KindUnusedLast));
      addr = ($urandom_range(99) < 85) ? bp_pool[$urandom_range(PoolSize - 1)] : $urandom();
      issue_request(kind, addr, HalfW'($urandom()));
   endtask

   // Empty the table, insert one address more than fits, then hit a present one
   task automatic fill_table();
      int base;
      base = $urandom_range(PoolSize - 1);
      issue_request(KIND_CLEAR, $urandom(), HalfW'($urandom()));
      for (int i = 0; i <= MaxEntries; i++)
         issue_request(KIND_INSERT, bp_pool[(base + i) % PoolSize], HalfW'($urandom()));
      issue_request(KIND_INSERT, bp_pool[base], HalfW'($urandom()));
   endtask

   initial begin : stimulus
      req_ch.valid          <= 1'b0;
      req_ch.kind           <= KIND_INSERT;
      req_ch.address        <= '0;
      req_ch.flash_halfword <= '0;
      reset                 <= 1'b1;
      bp_pool[0] = '0;
      bp_pool[1] = '1;
      for (int i = 2; i < PoolSize; i++)
         bp_pool[i] = $urandom();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, misses, extremes, every kind and each corner case
      issue_request(KIND_CLEAR, '0, '0);
      issue_request(KIND_REMOVE, bp_pool[2], '0);
      issue_request(KIND_SUSPEND, bp_pool[2], '0);
      issue_request(KIND_RESUME, bp_pool[2], '0);
      issue_request(KIND_INSERT, '0, '0);
      issue_request(KIND_INSERT, '1, '1);
      issue_request(KIND_INSERT, '1, 16'h1234);
      issue_request(KIND_INSERT, bp_pool[2], 16'h5A5A);
      issue_request(KIND_SUSPEND, '1, '0);
      issue_request(KIND_SUSPEND, '1, '0);
      issue_request(KIND_RESUME, '0, '0);
      issue_request(KIND_RESUME, '1, '0);
      issue_request(KIND_SUSPEND, '0, '0);
      issue_request(KIND_REMOVE, '0, '1);
      issue_request(KIND_REMOVE, '1, '0);
      issue_request(KIND_SUSPEND, bp_pool[2], '0);
      issue_request(KIND_CLEAR, '1, '1);
      issue_request(KIND_INSERT, bp_pool[3], 16'h0001);
      issue_request(KIND_INSERT, bp_pool[4], 16'h8000);
      issue_request(KIND_INSERT, bp_pool[5], 16'hFFFE);
      issue_request(KIND_SUSPEND, bp_pool[4], '0);
      issue_request(KIND_CLEAR, '0, '0);
      issue_request(KindUnusedFirst, '1, '1);
      issue_request(KindUnusedLast, '0, '0);

      // Random traffic under four idling profiles; two of them also fill the table
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_gap_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_gap_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_gap_pct = 31; receiver_stall_pct = 31; end
         endcase
         for (int n = 0; n < PhaseRequests; n++) begin
            random_request();
            if (phase % 2 == 1 && n == PhaseRequests / 2)
               fill_table();
         end
      end

      // Back-pressure: keep offering while responses are held off
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      hold_go            = 1'b1;
      for (int n = 0; n < 20; n++)
         random_request();

      // Drain and let any stray response show up
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (patches_pending == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("software_breakpoint_table_top verification clean");
      else
         $display("software_breakpoint_table_top verification failed");
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #5_000_000;
      $display("software_breakpoint_table_top verification failed");
      $finish;
   end

endmodule
